// File: rtl/oaids_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered array insert/delete/search core.
// No dependencies; every other file in rtl/ imports this package.
package oaids_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int REQ_W    = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [REQ_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_READ   = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_SEARCH = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // per-cell update controls
   typedef struct packed {
      logic load;        // take the new value
      logic from_lower;  // take the value of the cell below (insert shift)
      logic from_upper;  // take the value of the cell above (delete shift)
   } cell_ctrl_type;

endpackage

// File: rtl/oaids_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one element, shifts with its neighbors.
// Depends on oaids_pkg.
module oaids_cell (
   input  logic                    clock,
   input  oaids_pkg::cell_ctrl_type cell_ctrl,
   input  oaids_pkg::word_type     lower_value,
   input  oaids_pkg::word_type     upper_value,
   input  oaids_pkg::word_type     new_value,
   input  oaids_pkg::word_type     key,
   input  logic                    in_list,
   output oaids_pkg::word_type     value,
   output logic                    match
);
   import oaids_pkg::*;

   word_type value_ff;
   word_type value_in;

   always_comb begin
      value_in = value_ff;
      if (cell_ctrl.load) begin
         value_in = new_value;
      end else if (cell_ctrl.from_lower) begin
         value_in = lower_value;
      end else if (cell_ctrl.from_upper) begin
         value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = in_list && (value_ff == key);

endmodule

// File: rtl/oaids_pick.sv
`timescale 1ns / 1ps
// First-match encoder and positional read select across the cell chain.
// Depends on oaids_pkg.
module oaids_pick (
   input  logic [oaids_pkg::CAPACITY-1:0] match,
   input  oaids_pkg::word_type            cell_value [oaids_pkg::CAPACITY],
   input  logic [oaids_pkg::IDX_W-1:0]    read_idx,
   output logic                           hit,
   output logic [oaids_pkg::IDX_W-1:0]    hit_idx,
   output oaids_pkg::word_type            read_data
);
   import oaids_pkg::*;

   // scan from the top so the lowest matching index wins
   always_comb begin
      hit_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit       = |match;
   assign read_data = cell_value[read_idx];

endmodule

// File: rtl/ordered_array_insert_delete_search_core.sv
`timescale 1ns / 1ps
// Top level of the ordered array insert/delete/search core.
// Depends on oaids_pkg, oaids_cell and oaids_pick.
//
// A positional list of up to CAPACITY (16) signed 32-bit elements kept in a
// chain of cells, one element per cell, plus a fill count. Every request
// (clear, read, insert, delete, search) is carried out at the edge that accepts it: insert
// moves every cell above the position up by one in the same edge, delete moves
// them down, and search compares all cells against the key in parallel and
// encodes the lowest match. The result lands in an output register, so a new
// item is taken every cycle as long as the previous result is taken or the
// output register is empty; sustained rate is one item per cycle, bounded only
// by rsp_ready. Bad positions return an invalid-position status, insert into
// a full list returns a full status (position is checked first), and a search
// miss returns not-found. Unused request codes change nothing and return ok.
// No clearing pass is needed after reset: elements at or above the count are
// never visible.
module ordered_array_insert_delete_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [oaids_pkg::REQ_W-1:0]      req_type,
   input  logic [oaids_pkg::POS_W-1:0]      req_position,
   input  logic signed [oaids_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [oaids_pkg::STATUS_W-1:0]   rsp_status,
   output logic [oaids_pkg::IDX_W-1:0]      rsp_found_index,
   output logic signed [oaids_pkg::DATA_W-1:0] rsp_read_value,
   output logic [oaids_pkg::CNT_W-1:0]      rsp_count
);
   import oaids_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic                 accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 ins_go;
   logic                 del_go;
   status_type           status_in;
   logic [IDX_W-1:0]     found_in;
   word_type             read_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           rsp_status_ff;
   logic [IDX_W-1:0]     rsp_found_ff;
   word_type             rsp_read_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic [CAPACITY-1:0]  match;
   word_type             cell_value [CAPACITY];
   logic                 hit;
   logic [IDX_W-1:0]     hit_idx;
   word_type             pick_data;

   // take a new item whenever the output register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // cell chain: each cell decides from its index against the request position
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [POS_W-1:0] IDX = POS_W'(i);
      cell_ctrl_type ctrl;
      word_type      lower_v;
      word_type      upper_v;

      if (i == 0) begin : g_bottom
         assign lower_v = '0;
      end else begin : g_mid_lo
         assign lower_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign upper_v = '0;
      end else begin : g_mid_hi
         assign upper_v = cell_value[i+1];
      end

      assign ctrl.load       = accept && ins_go && (IDX == req_position);
      assign ctrl.from_lower = accept && ins_go && (IDX > req_position);
      assign ctrl.from_upper = accept && del_go && (IDX >= req_position);

      oaids_cell u_cell (
         .clock       (clock),
         .cell_ctrl   (ctrl),
         .lower_value (lower_v),
         .upper_value (upper_v),
         .new_value   (req_value),
         .key         (req_value),
         .in_list     (CNT_W'(i) < count_ff),
         .value       (cell_value[i]),
         .match       (match[i])
      );
   end

   oaids_pick u_pick (
      .match      (match),
      .cell_value (cell_value),
      .read_idx   (req_position[IDX_W-1:0]),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .read_data  (pick_data)
   );

   // decode the request: status, outputs, shift enables, next count
   always_comb begin
      status_in = ST_OK;
      found_in  = '0;
      read_in   = '0;
      count_in  = count_ff;
      ins_go    = 1'b0;
      del_go    = 1'b0;
      case (req_type)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ: begin
            if (req_position < count_ff) begin
               read_in = pick_data;
            end else begin
               status_in = ST_BAD_POS;
            end
         end
         OP_INSERT: begin
            if (req_position > count_ff) begin
               status_in = ST_BAD_POS;
            end else if (count_ff == CAP_CNT) begin
               status_in = ST_FULL;
            end else begin
               ins_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (req_position >= count_ff) begin
               status_in = ST_BAD_POS;
            end else begin
               del_go   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_SEARCH: begin
            if (hit) begin
               found_in = hit_idx;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            // unused codes: hold everything, report ok
         end
      endcase
   end

   // hold the result until taken; a new accept overwrites a drained slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_read_ff   <= read_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

// File: dv/list_check_pkg.sv
`timescale 1ns / 1ps
// Result tracker for the array list core: own copy of the list, expected results, compare.
// Depends on oaids_pkg for widths, request codes and status codes.
package list_check_pkg;
   import oaids_pkg::*;

   // request codes the block treats as no-ops
   localparam logic [REQ_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] found_index;
      word_type         read_value;
      logic [CNT_W-1:0] count;
   } list_result_type;

   class list_result_tracker;
      word_type        cells [CAPACITY];
      int unsigned     fill_count;
      list_result_type pending_results [$];
      int              results_seen;
      int              mismatches;
      int              failures;
      int              status_seen [4];

      function new();
         foreach (cells[i]) cells[i] = '0;
         fill_count = 0;
         results_seen = 0;
         mismatches = 0;
         failures = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // apply one request to the list copy and return what the block must answer
      function list_result_type apply_list_op(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos,
                                              word_type val);
         list_result_type res;
         int unsigned     i;
         bit              hit;
         res.status = ST_OK;
         res.found_index = '0;
         res.read_value = '0;
         hit = 1'b0;
         case (op)
            OP_CLEAR: begin
               fill_count = 0;
            end
            OP_READ: begin
               if (pos < fill_count) res.read_value = cells[pos[IDX_W-1:0]];
               else res.status = ST_BAD_POS;
            end
            OP_INSERT: begin
               if (pos > fill_count) begin
                  res.status = ST_BAD_POS;
               end else if (fill_count >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  for (i = fill_count; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos[IDX_W-1:0]] = val;
                  fill_count++;
               end
            end
            OP_DELETE: begin
               if (pos >= fill_count) begin
                  res.status = ST_BAD_POS;
               end else begin
                  for (i = pos; i + 1 < fill_count; i++) cells[i] = cells[i+1];
                  fill_count--;
               end
            end
            OP_SEARCH: begin
               res.status = ST_NOT_FOUND;
               for (i = 0; i < fill_count; i++) begin
                  if (!hit && cells[i] == val) begin
                     hit = 1'b1;
                     res.status = ST_OK;
                     res.found_index = i[IDX_W-1:0];
                  end
               end
            end
            default: ;
         endcase
         res.count = fill_count[CNT_W-1:0];
         return res;
      endfunction

      function void note_request(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos, word_type val);
         pending_results.push_back(apply_list_op(op, pos, val));
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] found,
                                   word_type rd, logic [CNT_W-1:0] cnt);
         list_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing outstanding: status %0d count %0d",
                        results_seen, status, cnt);
            return;
         end
         want = pending_results.pop_front();
         status_seen[want.status]++;
         if (status !== want.status || found !== want.found_index ||
             rd !== want.read_value || cnt !== want.count) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d mismatch: want status %0d idx %0d value %0d count %0d",
                        results_seen, want.status, want.found_index, want.read_value,
                        want.count);
               $display("result %0d mismatch: got status %0d idx %0d value %0d count %0d",
                        results_seen, status, found, rd, cnt);
            end
         end
      endfunction
   endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for ordered_array_insert_delete_search_core: clock, reset, drivers.
// Depends on oaids_pkg, list_check_pkg and the RTL of the core.
module tb_top;
   import oaids_pkg::*;
   import list_check_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [REQ_W-1:0]     req_type;
   logic [POS_W-1:0]     req_position;
   word_type             req_value;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_W-1:0]     rsp_found_index;
   word_type             rsp_read_value;
   logic [CNT_W-1:0]     rsp_count;

   // percent of cycles in which the sender holds off and the receiver stalls
   int send_idle_pct  = 31;
   int recv_stall_pct = 72;
   int items_sent     = 0;

   list_result_tracker sb;

   ordered_array_insert_delete_search_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Receiver: check whatever completes at this edge, then pick ready for the next one.
   // All sampled values are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_response(rsp_status, rsp_found_index, rsp_read_value, rsp_count);
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Small values collide often, which exercises duplicate keys; extremes hit the sign bit.
   function automatic word_type pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return word_type'(int'($urandom_range(0, 6)) - 3);
      if (roll < 35) return 32'sh8000_0000;
      if (roll < 40) return 32'sh7fff_ffff;
      return word_type'($urandom);
   endfunction

   // Present one item and hold it until the core takes it.
   task automatic send_item(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos, word_type val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, pos, val);
      items_sent++;
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed requests against the current list contents, plus some noise.
   task automatic run_phase(int n_items, int send_pct, int recv_pct);
      int                 roll;
      int unsigned        fill;
      logic [REQ_W-1:0]   op;
      logic [POS_W-1:0]   pos;
      word_type           val;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      drain_results();
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 99) == 0) drain_results();
         roll = $urandom_range(0, 99);
         fill = sb.fill_count;
         val  = pick_value();
         pos  = (fill == 0) ? '0 : POS_W'($urandom_range(0, fill - 1));
         if (roll < 2) begin
            op  = OP_CLEAR;
            pos = POS_W'($urandom_range(0, CAPACITY));
         end else if (roll < 4) begin
            op  = REQ_W'($urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST)));
            pos = POS_W'($urandom_range(0, CAPACITY));
         end else if (roll < 20) begin
            op = OP_READ;
         end else if (roll < 54) begin
            op  = OP_INSERT;
            pos = POS_W'($urandom_range(0, fill));
         end else if (roll < 76) begin
            op = OP_DELETE;
         end else if (roll < 94) begin
            op = OP_SEARCH;
            // most searches look for a key that is really in the list
            if (fill > 0 && $urandom_range(0, 9) < 7)
               val = sb.cells[$urandom_range(0, fill - 1)];
         end else begin
            op  = REQ_W'($urandom_range(int'(OP_CLEAR), int'(OP_SEARCH)));
            pos = POS_W'($urandom_range(0, CAPACITY));
         end
         send_item(op, pos, val);
      end
   endtask

   initial begin
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_type     <= OP_CLEAR;
      req_position <= '0;
      req_value    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, end and middle inserts, full list, duplicates.
      send_item(OP_CLEAR,  5'd0, 32'sd0);
      send_item(OP_READ,   5'd0, 32'sd0);          // read on empty list
      send_item(OP_DELETE, 5'd0, 32'sd0);          // delete on empty list
      send_item(OP_SEARCH, 5'd0, 32'sd0);          // search misses on empty list
      send_item(OP_INSERT, 5'd1, 32'sd9);          // insert past the count
      send_item(OP_INSERT, 5'd0, 32'sh8000_0000);
      send_item(OP_INSERT, 5'd1, 32'sh7fff_ffff);  // append at the end
      for (int k = 0; k < CAPACITY - 2; k++)
         send_item(OP_INSERT, 5'd1, 32'sd7);       // middle inserts, duplicate values
      send_item(OP_INSERT, 5'd16, 32'sd3);         // valid position but list is full
      send_item(OP_SEARCH, 5'd0, 32'sh7fff_ffff);  // hit in the last cell
      send_item(OP_SEARCH, 5'd0, 32'sd7);          // first of many equal keys
      send_item(OP_READ,   5'd15, 32'sd0);
      send_item(OP_READ,   5'd16, 32'sd0);         // read at the count
      send_item(OP_DELETE, 5'd15, 32'sd0);
      send_item(OP_DELETE, 5'd0, 32'sd0);
      send_item(OP_UNUSED_FIRST, 5'd31, 32'shffff_ffff);
      send_item(OP_UNUSED_LAST,  5'd0, 32'sd0);
      send_item(OP_CLEAR,  5'd16, 32'sd1);

      // Pacing: slow receiver, then slow sender, then full rate.
      run_phase(433, 31, 72);
      run_phase(433, 72, 31);
      run_phase(434, 0, 0);

      drain_results();
      repeat (8) @(posedge clock);
      sb.failures += sb.pending_results.size();

      $display("covered %0d requests over three pacing phases, %0d results checked",
               items_sent, sb.results_seen);
      $display("statuses seen: ok %0d, bad position %0d, full %0d, not found %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_BAD_POS],
               sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND]);
      if (sb.failures == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
